### hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types for the double-ended queue: opcodes, error codes and the
// control state encoding.
// ----------------------------------------------------------------------------
package dq_pkg;

    // operation codes carried by each input word
    typedef enum logic [2:0] {
        OP_QUERY      = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_CLEAR      = 3'd5
    } opcode_t;

    // error codes reported with each result word
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    // control states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

endpackage

### hw/rtl/dq_store.sv
// ----------------------------------------------------------------------------
// dq_store
// Element store of the queue: one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module dq_store #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [31:0]                wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [31:0]                rdata
);

    logic [31:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit values in a circular store.
//
//   channel  signals                                         direction
//   input    in_valid, in_stall, opcode, push_value          word in
//   output   out_valid, out_stall, popped_value, front_value, word out
//            back_value, element_count, error_code
//
// Query, push, clear and failed operations load the result word from idle.
// A pop that leaves at least one element also enters the read state, which
// stalls input: the new front or back value comes from the store read port.
// Front and back values are cached in registers, so no other read is needed.
// Reset empties the queue at once; the store itself is not cleared.
// A stalled result holds in the output register and blocks new input words.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] popped_value,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic [4:0]         element_count,
    output logic [1:0]         error_code
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   front_idx_reg, front_idx_next;
    logic [ADDR_W-1:0]   back_idx_reg, back_idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [31:0]         front_val_reg, front_val_next;
    logic [31:0]         back_val_reg, back_val_next;
    logic [31:0]         pend_popped_reg, pend_popped_next;
    logic                pend_front_reg, pend_front_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_popped_reg, out_popped_next;
    logic [31:0]         out_front_reg, out_front_next;
    logic [31:0]         out_back_reg, out_back_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;
    err_t                out_err_reg, out_err_next;

    logic                accept;
    logic                full;
    logic                empty;
    logic                one_left;
    logic [ADDR_W-1:0]   front_inc;
    logic [ADDR_W-1:0]   front_dec;
    logic [ADDR_W-1:0]   back_inc;
    logic [ADDR_W-1:0]   back_dec;
    logic [ADDR_W-1:0]   back_dec2;
    logic                st_we;
    logic [ADDR_W-1:0]   st_waddr;
    logic                st_re;
    logic [ADDR_W-1:0]   st_raddr;
    logic [31:0]         st_rdata;
    logic                need_read;
    logic                load_out;
    logic [31:0]         res_popped;
    err_t                res_err;

    // element store
    dq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (push_value),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // handshake
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // occupancy and wrapped slot neighbors
    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign one_left  = (count_reg == CNT_W'(1));
    assign front_inc = (front_idx_reg == LAST_SLOT) ? '0 : front_idx_reg + ADDR_W'(1);
    assign front_dec = (front_idx_reg == '0) ? LAST_SLOT : front_idx_reg - ADDR_W'(1);
    assign back_inc  = (back_idx_reg == LAST_SLOT) ? '0 : back_idx_reg + ADDR_W'(1);
    assign back_dec  = (back_idx_reg == '0) ? LAST_SLOT : back_idx_reg - ADDR_W'(1);
    assign back_dec2 = (back_dec == '0) ? LAST_SLOT : back_dec - ADDR_W'(1);

    // operation decode and next state
    always_comb
    begin
        state_next       = state_reg;
        front_idx_next   = front_idx_reg;
        back_idx_next    = back_idx_reg;
        count_next       = count_reg;
        front_val_next   = front_val_reg;
        back_val_next    = back_val_reg;
        pend_popped_next = pend_popped_reg;
        pend_front_next  = pend_front_reg;
        out_popped_next  = out_popped_reg;
        out_front_next   = out_front_reg;
        out_back_next    = out_back_reg;
        out_count_next   = out_count_reg;
        out_err_next     = out_err_reg;
        st_we            = 1'b0;
        st_waddr         = back_idx_reg;
        st_re            = 1'b0;
        st_raddr         = front_inc;
        need_read        = 1'b0;
        load_out         = 1'b0;
        res_popped       = '0;
        res_err          = ERR_OK;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_err = ERR_FULL;
                            end
                            else
                            begin
                                st_we         = 1'b1;
                                st_waddr      = back_idx_reg;
                                back_idx_next = back_inc;
                                count_next    = count_reg + CNT_W'(1);
                                back_val_next = push_value;
                                if (empty)
                                begin
                                    front_val_next = push_value;
                                end
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_err = ERR_FULL;
                            end
                            else
                            begin
                                st_we          = 1'b1;
                                st_waddr       = front_dec;
                                front_idx_next = front_dec;
                                count_next     = count_reg + CNT_W'(1);
                                front_val_next = push_value;
                                if (empty)
                                begin
                                    back_val_next = push_value;
                                end
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_err = ERR_EMPTY;
                            end
                            else
                            begin
                                res_popped    = back_val_reg;
                                back_idx_next = back_dec;
                                count_next    = count_reg - CNT_W'(1);
                                if (!one_left)
                                begin
                                    // new back element lives one slot further in
                                    need_read       = 1'b1;
                                    st_re           = 1'b1;
                                    st_raddr        = back_dec2;
                                    pend_front_next = 1'b0;
                                end
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_err = ERR_EMPTY;
                            end
                            else
                            begin
                                res_popped     = front_val_reg;
                                front_idx_next = front_inc;
                                count_next     = count_reg - CNT_W'(1);
                                if (!one_left)
                                begin
                                    need_read       = 1'b1;
                                    st_re           = 1'b1;
                                    st_raddr        = front_inc;
                                    pend_front_next = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            front_idx_next = '0;
                            back_idx_next  = '0;
                            count_next     = '0;
                        end
                        default:
                        begin
                            res_err = ERR_OK;
                        end
                    endcase

                    if (need_read)
                    begin
                        pend_popped_next = res_popped;
                        state_next       = ST_READ;
                    end
                    else
                    begin
                        load_out        = 1'b1;
                        out_popped_next = res_popped;
                        out_front_next  = (count_next == '0) ? '0 : front_val_next;
                        out_back_next   = (count_next == '0) ? '0 : back_val_next;
                        out_count_next  = count_next;
                        out_err_next    = res_err;
                    end
                end
            end
            ST_READ:
            begin
                // refill the cached end from the store
                if (pend_front_reg)
                begin
                    front_val_next = st_rdata;
                end
                else
                begin
                    back_val_next = st_rdata;
                end
                load_out        = 1'b1;
                out_popped_next = pend_popped_reg;
                out_front_next  = pend_front_reg ? st_rdata : front_val_reg;
                out_back_next   = pend_front_reg ? back_val_reg : st_rdata;
                out_count_next  = count_reg;
                out_err_next    = ERR_OK;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_idx_reg <= '0;
            back_idx_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            back_idx_reg  <= back_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        front_val_reg   <= front_val_next;
        back_val_reg    <= back_val_next;
        pend_popped_reg <= pend_popped_next;
        pend_front_reg  <= pend_front_next;
        out_popped_reg  <= out_popped_next;
        out_front_reg   <= out_front_next;
        out_back_reg    <= out_back_next;
        out_count_reg   <= out_count_next;
        out_err_reg     <= out_err_next;
    end

    // output ports
    assign out_valid     = out_valid_reg;
    assign popped_value  = out_popped_reg;
    assign front_value   = out_front_reg;
    assign back_value    = out_back_reg;
    assign element_count = 5'(out_count_reg);
    assign error_code    = out_err_reg;

endmodule

### hw/rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the double-ended queue results, bound to the core.
// ----------------------------------------------------------------------------
module dq_checker
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] popped_value,
    input logic signed [31:0] front_value,
    input logic signed [31:0] back_value,
    input logic [4:0]         element_count,
    input logic [1:0]         error_code
);

    // stalled result stays on the port
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(popped_value)
            && $stable(element_count))
        else $error("stalled result word changed");

    // empty queue shows zero at both ends
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && element_count == 5'd0 && DEPTH < 32
            |-> front_value == 32'sd0 && back_value == 32'sd0)
        else $error("empty queue reports nonzero end value");

    // failed pop removes nothing and reports an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_EMPTY
            |-> popped_value == 32'sd0 && element_count == 5'd0)
        else $error("pop on empty queue reported wrong result");

    // refused push only happens at full occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_FULL |-> element_count == 5'(DEPTH))
        else $error("push refused below full occupancy");

    // single element is both front and back
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && element_count == 5'd1 && DEPTH < 32
            |-> front_value == back_value)
        else $error("single element front and back differ");

endmodule

bind double_ended_queue_core dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
